>>> src/ora_pkg.sv
// Shared constants, pipeline types and step functions for the obstacle repulsion block.
// Used by obstacle_repulsion_accel and tb_top; depends on nothing else.
package ora_pkg;

    localparam int unsigned GAIN_W   = 26;
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE = 2'd1;
    localparam logic [GAIN_W-1:0] REPEL_RESET = 26'd0;
    localparam logic [GAIN_W-1:0] BRAKE_RESET = 26'd6553600;

    localparam int unsigned SQ_STEPS = 31;
    localparam int unsigned DV_STEPS = 31;

    localparam logic [32:0] CLAMP_RAW = 33'd6554;
    localparam logic [27:0] CLAMP_SQ  = 28'd42954916;
    localparam logic [29:0] CLAMP_MAG = 30'd429522944;
    localparam logic signed [44:0] ACC_LIMIT = 45'sd655360;

    typedef struct packed {
        logic [2:0]        neg;
        logic [2:0][29:0]  s;
        logic [2:0][31:0]  v;
        logic              zero;
        logic              clamped;
    } t_item;

    typedef struct packed {
        logic [62:0] rem;
        logic [62:0] root;
    } t_sq;

    typedef struct packed {
        t_item it;
        t_sq   nrm;
        t_sq   mag;
    } t_sqst;

    typedef struct packed {
        t_item             it;
        logic [30:0]       n;
        logic [2:0][61:0]  rem;
        logic [2:0][30:0]  q;
        logic [55:0]       kp_prod;
    } t_dvst;

    function automatic t_sq sqrt_step(t_sq st, int k);
        logic [62:0] bitv;
        logic [63:0] trial;
        t_sq         res;
        bitv  = 63'(1) << (2 * (int'(SQ_STEPS) - 1 - k));
        trial = {1'b0, st.root} + {1'b0, bitv};
        if ({1'b0, st.rem} >= trial) begin
            res.rem  = st.rem - trial[62:0];
            res.root = (st.root >> 1) + bitv;
        end else begin
            res.rem  = st.rem;
            res.root = st.root >> 1;
        end
        return res;
    endfunction

    function automatic t_dvst div_step(t_dvst st, int k);
        int          b;
        logic [61:0] sub;
        t_dvst       res;
        res = st;
        b   = int'(DV_STEPS) - 1 - k;
        sub = 62'(st.n) << b;
        for (int i = 0; i < 3; i++) begin
            if (st.rem[i] >= sub) begin
                res.rem[i]  = st.rem[i] - sub;
                res.q[i][b] = 1'b1;
            end
        end
        return res;
    endfunction

endpackage

>>> src/obstacle_repulsion_accel.sv
// Pipelined potential-field obstacle avoidance: one pose and velocity beat in, one
// acceleration beat out. Depends on ora_pkg for types, constants and step functions.
//
//  channel | signals                                   | direction
//  input   | i_valid, o_stall, i_pos_*, i_obst_*, i_vel_* | into block
//  output  | o_valid, i_stall, o_acc_x, o_acc_y, o_acc_z | out of block
//  config  | i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data | into block
//
// A new beat can enter every cycle unless an output beat is stalled, which freezes the
// whole pipeline; beats pass the 31-stage square root and the 31-stage divider. Reset
// is synchronous, clears the valid bits and loads the reset gains; no clearing pass.
module obstacle_repulsion_accel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_obst_x,
    input  logic [31:0] i_obst_y,
    input  logic [31:0] i_obst_z,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_vel_z,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_acc_x,
    output logic [31:0] o_acc_y,
    output logic [31:0] o_acc_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [ora_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ora_pkg::GAIN_W-1:0]    i_cfg_data
);

    logic w_adv;
    logic [2:0][31:0] w_pos, w_obst, w_vel;

    logic [ora_pkg::GAIN_W-1:0] r_repel_gain, r_brake_gain;

    logic              r1_vld;
    logic [2:0]        r1_neg, n1_neg;
    logic [2:0][32:0]  r1_a, n1_a;
    logic [32:0]       r1_m, n1_m;
    logic [2:0][31:0]  r_p0_v;

    logic              r2_vld;
    ora_pkg::t_item    r2_it, n2_it;
    logic [27:0]       r2_raw, n2_raw;

    logic              r3_vld;
    ora_pkg::t_item    r3_it;
    logic [27:0]       r3_raw;
    logic [2:0][59:0]  r3_sq, n3_sq;

    logic [ora_pkg::SQ_STEPS:0] r_sq_vld;
    ora_pkg::t_sqst    r_sq [ora_pkg::SQ_STEPS+1];
    ora_pkg::t_sqst    n_sq [ora_pkg::SQ_STEPS+1];

    logic [ora_pkg::DV_STEPS:0] r_dv_vld;
    ora_pkg::t_dvst    r_dv [ora_pkg::DV_STEPS+1];
    ora_pkg::t_dvst    n_dv [ora_pkg::DV_STEPS+1];

    logic              r_p1_vld, r_p1_zero;
    logic [2:0][31:0]  r_p1_u, n_p1_u;
    logic [2:0][63:0]  r_p1_pv, n_p1_pv;
    logic [24:0]       r_p1_rq, n_p1_rq;

    logic              r_p2_vld, r_p2_zero;
    logic [2:0][31:0]  r_p2_u;
    logic [65:0]       r_p2_dot, n_p2_dot;
    logic [24:0]       r_p2_rq;

    logic              r_p3_vld, r_p3_zero;
    logic [2:0][31:0]  r_p3_u;
    logic [32:0]       r_p3_dq, n_p3_dq;
    logic [24:0]       r_p3_rq;

    logic              r_p4_vld, r_p4_zero;
    logic [2:0][31:0]  r_p4_u;
    logic [58:0]       r_p4_bprod, n_p4_bprod;
    logic [24:0]       r_p4_rq;

    logic              r_p5_vld, r_p5_zero;
    logic [2:0][31:0]  r_p5_u;
    logic [44:0]       r_p5_g, n_p5_g;

    logic              r_p6_vld, r_p6_zero, r_p6_big, n_p6_big, r_p6_gneg;
    logic [2:0][31:0]  r_p6_u;
    logic [2:0][53:0]  r_p6_gu, n_p6_gu;

    logic              r_out_vld;
    logic [2:0][31:0]  r_acc, n_acc;

    assign w_pos  = {i_pos_z, i_pos_y, i_pos_x};
    assign w_obst = {i_obst_z, i_obst_y, i_obst_x};
    assign w_vel  = {i_vel_z, i_vel_y, i_vel_x};

    assign w_adv       = !(r_out_vld && i_stall);
    assign o_stall     = r_out_vld && i_stall;
    assign o_valid     = r_out_vld;
    assign o_acc_x     = r_acc[0];
    assign o_acc_y     = r_acc[1];
    assign o_acc_z     = r_acc[2];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_repel_gain <= ora_pkg::REPEL_RESET;
            r_brake_gain <= ora_pkg::BRAKE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ora_pkg::CFG_REPEL: r_repel_gain <= i_cfg_data;
                ora_pkg::CFG_BRAKE: r_brake_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic [32:0] diff;
        n1_m = '0;
        for (int i = 0; i < 3; i++) begin
            diff      = {w_pos[i][31], w_pos[i]} - {w_obst[i][31], w_obst[i]};
            n1_neg[i] = diff[32];
            n1_a[i]   = diff[32] ? (33'd0 - diff) : diff;
            if (n1_a[i] > n1_m) begin
                n1_m = n1_a[i];
            end
        end
    end

    always_comb begin
        logic [5:0] lead;
        lead = '0;
        for (int b = 0; b < 33; b++) begin
            if (r1_m[b]) begin
                lead = 6'(b);
            end
        end
        n2_it.neg = r1_neg;
        n2_it.v   = r_p0_v;
        for (int i = 0; i < 3; i++) begin
            if (lead >= 6'd29) begin
                n2_it.s[i] = 30'(r1_a[i] >> (lead - 6'd29));
            end else begin
                n2_it.s[i] = 30'(r1_a[i] << (6'd29 - lead));
            end
        end
        n2_raw = 28'(r1_a[0][12:0]) * 28'(r1_a[0][12:0])
               + 28'(r1_a[1][12:0]) * 28'(r1_a[1][12:0])
               + 28'(r1_a[2][12:0]) * 28'(r1_a[2][12:0]);
        n2_it.zero    = (r1_m == 33'd0);
        n2_it.clamped = (r1_m > ora_pkg::CLAMP_RAW) || (n2_raw > ora_pkg::CLAMP_SQ);
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n3_sq[i] = 60'(r2_it.s[i]) * 60'(r2_it.s[i]);
        end
    end

    always_comb begin
        n_sq[0].it       = r3_it;
        n_sq[0].nrm.rem  = 63'(r3_sq[0]) + 63'(r3_sq[1]) + 63'(r3_sq[2]);
        n_sq[0].nrm.root = '0;
        n_sq[0].mag.rem  = 63'({r3_raw, 32'd0});
        n_sq[0].mag.root = '0;
        for (int k = 0; k < int'(ora_pkg::SQ_STEPS); k++) begin
            n_sq[k+1].it  = r_sq[k].it;
            n_sq[k+1].nrm = ora_pkg::sqrt_step(r_sq[k].nrm, k);
            n_sq[k+1].mag = ora_pkg::sqrt_step(r_sq[k].mag, k);
        end
    end

    always_comb begin
        logic [29:0] mag;
        mag = r_sq[ora_pkg::SQ_STEPS].it.clamped ? ora_pkg::CLAMP_MAG
                                                  : r_sq[ora_pkg::SQ_STEPS].mag.root[29:0];
        n_dv[0].it = r_sq[ora_pkg::SQ_STEPS].it;
        n_dv[0].n  = r_sq[ora_pkg::SQ_STEPS].nrm.root[30:0];
        for (int i = 0; i < 3; i++) begin
            n_dv[0].rem[i] = 62'({r_sq[ora_pkg::SQ_STEPS].it.s[i], 30'd0})
                           + 62'(r_sq[ora_pkg::SQ_STEPS].nrm.root[30:1]);
            n_dv[0].q[i]   = '0;
        end
        n_dv[0].kp_prod = 56'(r_repel_gain) * 56'(mag);
        for (int k = 0; k < int'(ora_pkg::DV_STEPS); k++) begin
            n_dv[k+1] = ora_pkg::div_step(r_dv[k], k);
        end
    end

    always_comb begin
        logic [55:0] rq_sum;
        for (int i = 0; i < 3; i++) begin
            n_p1_u[i]  = r_dv[ora_pkg::DV_STEPS].it.neg[i]
                       ? (32'd0 - 32'(r_dv[ora_pkg::DV_STEPS].q[i]))
                       : 32'(r_dv[ora_pkg::DV_STEPS].q[i]);
            n_p1_pv[i] = 64'($signed(r_dv[ora_pkg::DV_STEPS].it.v[i]) * $signed(n_p1_u[i]));
        end
        rq_sum  = r_dv[ora_pkg::DV_STEPS].kp_prod + 56'(64'd1 << 31);
        n_p1_rq = rq_sum[55:31] >> 1;
    end

    always_comb begin
        n_p2_dot = 66'd0 - ({{2{r_p1_pv[0][63]}}, r_p1_pv[0]}
                          + {{2{r_p1_pv[1][63]}}, r_p1_pv[1]}
                          + {{2{r_p1_pv[2][63]}}, r_p1_pv[2]});
    end

    always_comb begin
        logic [65:0] dsum;
        dsum = r_p2_dot + 66'(64'd1 << 29);
        if (!r_p2_dot[65] && (r_p2_dot != 66'd0)) begin
            n_p3_dq = dsum[62:30];
        end else begin
            n_p3_dq = '0;
        end
    end

    assign n_p4_bprod = 59'(r_brake_gain) * 59'(r_p3_dq);

    always_comb begin
        logic [58:0] bsum;
        bsum   = r_p4_bprod + 59'(1 << 15);
        n_p5_g = {2'b00, bsum[58:16]} - 45'(r_p4_rq);
    end

    always_comb begin
        n_p6_big = ($signed(r_p5_g) > ora_pkg::ACC_LIMIT) || ($signed(r_p5_g) < -ora_pkg::ACC_LIMIT);
        for (int i = 0; i < 3; i++) begin
            n_p6_gu[i] = 54'($signed(r_p5_g[21:0]) * $signed(r_p5_u[i]));
        end
    end

    always_comb begin
        logic [30:0] umag;
        logic [16:0] ur;
        logic [53:0] gmag;
        logic [53:0] gsum;
        logic        neg;
        for (int i = 0; i < 3; i++) begin
            neg  = 1'b0;
            umag = r_p6_u[i][31] ? 31'(32'd0 - r_p6_u[i]) : r_p6_u[i][30:0];
            ur   = 17'((umag + 31'(1 << 13)) >> 14);
            gmag = r_p6_gu[i][53] ? (54'd0 - r_p6_gu[i]) : r_p6_gu[i];
            gsum = gmag + 54'(1 << 29);
            if (r_p6_zero) begin
                n_acc[i] = '0;
            end else if (r_p6_big) begin
                neg      = r_p6_u[i][31] ^ r_p6_gneg;
                n_acc[i] = neg ? (32'd0 - 32'(ur)) : 32'(ur);
            end else begin
                neg      = r_p6_gu[i][53];
                n_acc[i] = neg ? (32'd0 - 32'(gsum[53:30])) : 32'(gsum[53:30]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld    <= 1'b0;
            r2_vld    <= 1'b0;
            r3_vld    <= 1'b0;
            r_sq_vld  <= '0;
            r_dv_vld  <= '0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_p5_vld  <= 1'b0;
            r_p6_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld    <= i_valid;
            r2_vld    <= r1_vld;
            r3_vld    <= r2_vld;
            r_sq_vld  <= {r_sq_vld[ora_pkg::SQ_STEPS-1:0], r3_vld};
            r_dv_vld  <= {r_dv_vld[ora_pkg::DV_STEPS-1:0], r_sq_vld[ora_pkg::SQ_STEPS]};
            r_p1_vld  <= r_dv_vld[ora_pkg::DV_STEPS];
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_p4_vld  <= r_p3_vld;
            r_p5_vld  <= r_p4_vld;
            r_p6_vld  <= r_p5_vld;
            r_out_vld <= r_p6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_neg <= n1_neg;
            r1_a   <= n1_a;
            r1_m   <= n1_m;
            r_p0_v <= w_vel;
            r2_it  <= n2_it;
            r2_raw <= n2_raw;
            r3_it  <= r2_it;
            r3_raw <= r2_raw;
            r3_sq  <= n3_sq;
            for (int k = 0; k <= int'(ora_pkg::SQ_STEPS); k++) begin
                r_sq[k] <= n_sq[k];
            end
            for (int k = 0; k <= int'(ora_pkg::DV_STEPS); k++) begin
                r_dv[k] <= n_dv[k];
            end
            r_p1_zero  <= r_dv[ora_pkg::DV_STEPS].it.zero;
            r_p1_u     <= n_p1_u;
            r_p1_pv    <= n_p1_pv;
            r_p1_rq    <= n_p1_rq;
            r_p2_zero  <= r_p1_zero;
            r_p2_u     <= r_p1_u;
            r_p2_dot   <= n_p2_dot;
            r_p2_rq    <= r_p1_rq;
            r_p3_zero  <= r_p2_zero;
            r_p3_u     <= r_p2_u;
            r_p3_dq    <= n_p3_dq;
            r_p3_rq    <= r_p2_rq;
            r_p4_zero  <= r_p3_zero;
            r_p4_u     <= r_p3_u;
            r_p4_bprod <= n_p4_bprod;
            r_p4_rq    <= r_p3_rq;
            r_p5_zero  <= r_p4_zero;
            r_p5_u     <= r_p4_u;
            r_p5_g     <= n_p5_g;
            r_p6_zero  <= r_p5_zero;
            r_p6_u     <= r_p5_u;
            r_p6_big   <= n_p6_big;
            r_p6_gneg  <= r_p5_g[44];
            r_p6_gu    <= n_p6_gu;
            r_acc      <= n_acc;
        end
    end

    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_vld && !r2_it.zero |-> ((r2_it.s[0] | r2_it.s[1] | r2_it.s[2]) >> 29) == 30'd1)
        else $error("normalized error vector lost its leading bit");

    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[0] && !r_dv[0].it.zero |-> r_dv[0].n[30:29] != 2'b00)
        else $error("divisor below normalized range");

    a_quot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_vld[ora_pkg::DV_STEPS] && !r_dv[ora_pkg::DV_STEPS].it.zero |->
            r_dv[ora_pkg::DV_STEPS].q[0] <= 31'(1 << 30) &&
            r_dv[ora_pkg::DV_STEPS].q[1] <= 31'(1 << 30) &&
            r_dv[ora_pkg::DV_STEPS].q[2] <= 31'(1 << 30))
        else $error("unit vector component exceeds one");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_p6_vld && r_p6_zero |=>
            o_acc_x == 32'd0 && o_acc_y == 32'd0 && o_acc_z == 32'd0)
        else $error("zero error beat produced a nonzero result");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            $signed(o_acc_x) <= 32'sd655360 && $signed(o_acc_x) >= -32'sd655360 &&
            $signed(o_acc_y) <= 32'sd655360 && $signed(o_acc_y) >= -32'sd655360 &&
            $signed(o_acc_z) <= 32'sd655360 && $signed(o_acc_z) >= -32'sd655360)
        else $error("acceleration outside the limit");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for obstacle_repulsion_accel: directed and random pose/velocity beats
// checked against an in-bench fixed-point predictor. Depends on ora_pkg and the RTL.
module tb_top;

    typedef logic [2:0][31:0] t_vec3;

    localparam longint unsigned CLAMP_LEN = 64'd6554;
    localparam longint ACC_LIM = 64'sd655360;
    localparam logic [ora_pkg::GAIN_W-1:0] GAIN_MAX = 26'd67043328;
    localparam logic [ora_pkg::GAIN_W-1:0] GAIN_ONE = 26'd65536;
    localparam logic [ora_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [ora_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int LIMIT_CYCLES = 400000;
    localparam int TAIL_CYCLES = 90;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [31:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic [31:0] i_obst_x = '0, i_obst_y = '0, i_obst_z = '0;
    logic [31:0] i_vel_x = '0, i_vel_y = '0, i_vel_z = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic [31:0] o_acc_x, o_acc_y, o_acc_z;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [ora_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ora_pkg::GAIN_W-1:0] i_cfg_data = '0;

    logic [ora_pkg::GAIN_W-1:0] kp_model = ora_pkg::REPEL_RESET;
    logic [ora_pkg::GAIN_W-1:0] kv_model = ora_pkg::BRAKE_RESET;
    t_vec3 accel_q[$];
    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    obstacle_repulsion_accel i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_obst_x(i_obst_x), .i_obst_y(i_obst_y), .i_obst_z(i_obst_z),
        .i_vel_x(i_vel_x), .i_vel_y(i_vel_y), .i_vel_z(i_vel_z),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_acc_x(o_acc_x), .o_acc_y(o_acc_y), .o_acc_z(o_acc_z),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    function automatic longint unsigned isqrt_u64(longint unsigned x);
        longint unsigned r = 0;
        longint unsigned b = 64'h4000_0000_0000_0000;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint round_half(longint x, int sh);
        longint unsigned mg;
        mg = x < 0 ? longint'(-x) : x;
        mg = (mg + (64'd1 << (sh - 1))) >> sh;
        return x < 0 ? -longint'(mg) : longint'(mg);
    endfunction

    function automatic t_vec3 accel_for(t_vec3 p, t_vec3 q, t_vec3 v);
        longint e[3], u[3], dot, g, r;
        longint unsigned a[3], s[3], m, rsum, sum, n, magc, rq, bq, dq, qt;
        bit clamped;
        t_vec3 res;
        m = 0; rsum = 0; bq = 0; dot = 0;
        for (int i = 0; i < 3; i++) begin
            e[i] = longint'($signed(p[i])) - longint'($signed(q[i]));
            a[i] = e[i] < 0 ? longint'(-e[i]) : e[i];
            if (a[i] > m) m = a[i];
        end
        if (m == 0) return '0;
        if (m > CLAMP_LEN) begin
            clamped = 1'b1;
        end else begin
            for (int i = 0; i < 3; i++) rsum += a[i] * a[i];
            clamped = rsum > CLAMP_LEN * CLAMP_LEN;
        end
        for (int i = 0; i < 3; i++) s[i] = a[i];
        while (m >= 64'h4000_0000) begin
            for (int i = 0; i < 3; i++) s[i] >>= 1;
            m >>= 1;
        end
        while (m < 64'h2000_0000) begin
            for (int i = 0; i < 3; i++) s[i] <<= 1;
            m <<= 1;
        end
        sum = s[0] * s[0] + s[1] * s[1] + s[2] * s[2];
        n = isqrt_u64(sum);
        for (int i = 0; i < 3; i++) begin
            qt = ((s[i] << 30) + (n >> 1)) / n;
            u[i] = e[i] < 0 ? -longint'(qt) : longint'(qt);
        end
        magc = clamped ? (CLAMP_LEN << 16) : isqrt_u64(rsum << 32);
        rq = (64'(kp_model) * magc + (64'd1 << 31)) >> 32;
        for (int i = 0; i < 3; i++) dot -= longint'($signed(v[i])) * u[i];
        if (dot > 0) begin
            dq = (longint'(dot) + (64'd1 << 29)) >> 30;
            bq = (64'(kv_model) * dq + (64'd1 << 15)) >> 16;
        end
        g = longint'(bq) - longint'(rq);
        for (int i = 0; i < 3; i++) begin
            if (g > ACC_LIM || g < -ACC_LIM) begin
                r = round_half(u[i], 14);
                r = g < 0 ? -r : r;
            end else begin
                r = round_half(g * u[i], 30);
            end
            res[i] = r[31:0];
        end
        return res;
    endfunction

    function automatic t_vec3 mk(int x, int y, int z);
        return {32'(z), 32'(y), 32'(x)};
    endfunction

    always @(posedge i_clk) begin
        t_vec3 got, want;
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("tb_top: errors");
            $finish;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_acc_z, o_acc_y, o_acc_x};
            if (accel_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat: %h", got);
            end else begin
                want = accel_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        for (int i = 0; i < 3; i++)
                            if (got[i] !== want[i])
                                $display("acc[%0d]: expected %h, got %h", i, want[i], got[i]);
                end
            end
        end
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_beat(t_vec3 p, t_vec3 q, t_vec3 v);
        i_valid <= 1'b1;
        {i_pos_z, i_pos_y, i_pos_x} <= p;
        {i_obst_z, i_obst_y, i_obst_x} <= q;
        {i_vel_z, i_vel_y, i_vel_x} <= v;
        do @(posedge i_clk); while (o_stall);
        accel_q.push_back(accel_for(p, q, v));
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic drain;
        i_valid <= 1'b0;
        while (accel_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [ora_pkg::CFG_IDX_W-1:0] idx,
                             logic [ora_pkg::GAIN_W-1:0] data, bit last);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == ora_pkg::CFG_REPEL) kp_model = data;
        else if (idx == ora_pkg::CFG_BRAKE) kv_model = data;
        if (last) i_cfg_valid <= 1'b0;
    endtask

    task automatic set_gains(logic [ora_pkg::GAIN_W-1:0] kp, logic [ora_pkg::GAIN_W-1:0] kv);
        drain();
        cfg_write(ora_pkg::CFG_REPEL, kp, 1'b0);
        cfg_write(ora_pkg::CFG_BRAKE, kv, 1'b1);
    endtask

    function automatic int near_delta(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    task automatic send_random;
        t_vec3 q, p, v;
        int mode;
        mode = $urandom_range(9);
        q = {$urandom, $urandom, $urandom};
        case (mode)
            0, 9: p = {$urandom, $urandom, $urandom};
            1, 2, 3, 4: p = q + mk(near_delta(8000), near_delta(8000), near_delta(8000));
            5: p = q + mk(near_delta(4000), 0, near_delta(4000));
            6, 7: p = q + mk(near_delta(1 << 20), near_delta(1 << 20), near_delta(1 << 20));
            default: p = q;
        endcase
        if ($urandom_range(1)) v = {$urandom, $urandom, $urandom};
        else v = mk(near_delta(1 << 18), near_delta(1 << 18), near_delta(1 << 18));
        send_beat(p, q, v);
    endtask

    task automatic test_directed;
        send_beat(mk(0, 0, 0), mk(0, 0, 0), mk(123, -4, 99));
        send_beat({3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}});
        send_beat({3{32'h7FFF_FFFF}}, {3{32'h8000_0000}}, {3{32'h8000_0000}});
        send_beat({3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}, {3{32'h7FFF_FFFF}});
        send_beat(mk(6554, 0, 0), mk(0, 0, 0), mk(-65536, 0, 0));
        send_beat(mk(6555, 0, 0), mk(0, 0, 0), mk(-65536, 0, 0));
        send_beat(mk(3000, 3000, 3000), mk(0, 0, 0), mk(-9000, -9000, -9000));
        send_beat(mk(3784, 3784, 3784), mk(0, 0, 0), mk(-500, 20, 7));
        send_beat(mk(1, 0, 0), mk(0, 0, 0), mk(-1, 0, 0));
        send_beat(mk(0, 0, -1), mk(0, 0, 0), {3{32'h7FFF_FFFF}});
        send_beat(mk(-5, 7, -3), mk(0, 0, 0), mk(-5000, 7000, -3000));
        send_beat(mk(100, 200, 300), mk(100, 200, 300), {3{32'h8000_0000}});
    endtask

    task automatic test_limit_edge;
        set_gains(26'd0, GAIN_ONE);
        send_beat(mk(1000, 0, 0), mk(0, 0, 0), mk(-655360, 0, 0));
        send_beat(mk(1000, 0, 0), mk(0, 0, 0), mk(-655361, 0, 0));
        send_beat(mk(0, -1000, 0), mk(0, 0, 0), mk(0, 655360, 0));
        drain();
        cfg_write(CFG_SPARE_A, GAIN_MAX, 1'b0);
        cfg_write(CFG_SPARE_B, GAIN_MAX, 1'b0);
        cfg_write(ora_pkg::CFG_REPEL, GAIN_MAX, 1'b1);
        send_beat(mk(6554, 0, 0), mk(0, 0, 0), mk(0, 0, 0));
        send_beat(mk(2, 3, 0), mk(0, 0, 0), mk(1, 1, 1));
        send_beat(mk(0, 0, 40), mk(0, 0, 0), mk(0, 0, -1 << 24));
    endtask

    task automatic test_random_phase(int s_pct, int r_pct, logic [ora_pkg::GAIN_W-1:0] kp,
                                     logic [ora_pkg::GAIN_W-1:0] kv, int count);
        set_gains(kp, kv);
        send_idle_pct = s_pct;
        stall_pct = r_pct;
        for (int i = 0; i < count; i++) begin
            send_random();
            if (i == count / 2) drain();
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_limit_edge();
        test_random_phase(19, 85, 26'($urandom_range(1 << 22)), 26'($urandom_range(1 << 24)), 650);
        test_random_phase(85, 19, GAIN_MAX, 26'd0, 650);
        test_random_phase(0, 0, 26'd0, GAIN_MAX, 650);
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule
